// File: sv/dqdel_pkg.sv
// ----------------------------------------------------------------------------
// dqdel_pkg
// Types, codes and sizes shared by the deque with delete-by-value.
// ----------------------------------------------------------------------------
package dqdel_pkg;

    localparam int DQ_DEPTH = 16;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = 5;

    // request function codes
    localparam logic [2:0] F_INS_FRONT = 3'd0;
    localparam logic [2:0] F_INS_REAR  = 3'd1;
    localparam logic [2:0] F_DEL_FRONT = 3'd2;
    localparam logic [2:0] F_DEL_REAR  = 3'd3;
    localparam logic [2:0] F_DEL_VAL   = 3'd4;
    localparam logic [2:0] F_LIST      = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // cell modes, broadcast along the chain
    typedef logic [2:0] t_cmode;
    localparam t_cmode M_HOLD      = 3'd0;
    localparam t_cmode M_INS_FRONT = 3'd1;
    localparam t_cmode M_INS_REAR  = 3'd2;
    localparam t_cmode M_DEL_FRONT = 3'd3;
    localparam t_cmode M_DEL_VAL   = 3'd4;
    localparam t_cmode M_ROTATE    = 3'd5;

    typedef struct packed {
        logic [2:0]              func;
        logic signed [VAL_W-1:0] value;
    } t_dq_req;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] item_value;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } t_dq_res;

endpackage

// File: sv/dqdel_cell.sv
// ----------------------------------------------------------------------------
// dqdel_cell
// One storage position of the deque; shifts with its neighbours.
// ----------------------------------------------------------------------------
module dqdel_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic                             i_clk,
    input  dqdel_pkg::t_cmode                i_mode,
    input  logic signed [dqdel_pkg::VAL_W-1:0] i_val,
    input  logic [CW-1:0]                    i_count,
    input  logic signed [dqdel_pkg::VAL_W-1:0] i_left,
    input  logic signed [dqdel_pkg::VAL_W-1:0] i_right,
    input  logic signed [dqdel_pkg::VAL_W-1:0] i_front,
    input  logic                             i_hit,
    output logic signed [dqdel_pkg::VAL_W-1:0] o_data,
    output logic                             o_hit,
    output logic signed [dqdel_pkg::VAL_W-1:0] o_tail
);
    import dqdel_pkg::*;

    localparam bit IS_FRONT = (INDEX == 0);

    logic signed [VAL_W-1:0] r_data;
    logic signed [VAL_W-1:0] n_data;
    logic occupied;
    logic is_tail;
    logic at_rear;
    logic eq;

    assign occupied = CW'(INDEX) < i_count;
    assign is_tail  = CW'(INDEX + 1) == i_count;
    assign at_rear  = CW'(INDEX) == i_count;
    assign eq       = occupied && (r_data == i_val);
    assign o_hit    = i_hit | eq;
    assign o_data   = r_data;
    assign o_tail   = is_tail ? r_data : '0;

    always_comb begin
        n_data = r_data;
        unique case (i_mode)
            M_INS_FRONT: n_data = IS_FRONT ? i_val : i_left;
            M_INS_REAR:  if (at_rear) n_data = i_val;
            M_DEL_FRONT: n_data = i_right;
            M_DEL_VAL:   if (o_hit) n_data = i_right;
            M_ROTATE:    n_data = is_tail ? i_front : i_right;
            default:     n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// File: sv/deque_with_delete_by_value.sv
// ----------------------------------------------------------------------------
// deque_with_delete_by_value
// Deque of signed words in a chain of shifting cells, with delete-by-value.
// ----------------------------------------------------------------------------
// Channel   Handshake           Payload
// request   start / busy        i_req  (func, value)
// result    o_res_valid strobe  o_res  (status, item_value, count, last)
//
// One request per cycle while not busy; a non-list result appears in the next cycle.
// A list request holds busy while the chain rotates once,
// emitting the front cell each cycle; the result with last set ends it.
// Reset clears the count and the list sequencer; cell contents are left.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module deque_with_delete_by_value #(
    parameter int DEPTH = dqdel_pkg::DQ_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  dqdel_pkg::t_dq_req  i_req,
    output logic                o_res_valid,
    output dqdel_pkg::t_dq_res  o_res
);
    import dqdel_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] n_idx;
    logic          r_listing;
    logic          n_listing;
    logic          r_res_valid;
    logic          n_res_valid;
    t_dq_res       r_res;
    t_dq_res       n_res;
    t_cmode        mode;

    logic signed [VAL_W-1:0] w_data [DEPTH];
    logic signed [VAL_W-1:0] w_tail [DEPTH];
    logic                    w_hit  [DEPTH];
    logic signed [VAL_W-1:0] tail_val;
    logic                    accept;
    logic                    empty;
    logic                    full;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            dqdel_cell #(
                .INDEX (g),
                .CW    (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_mode  (mode),
                .i_val   (i_req.value),
                .i_count (r_count),
                .i_left  ((g == 0) ? i_req.value : w_data[(g == 0) ? 0 : g - 1]),
                .i_right ((g == DEPTH - 1) ? w_data[0] : w_data[(g == DEPTH - 1) ? g : g + 1]),
                .i_front (w_data[0]),
                .i_hit   ((g == 0) ? 1'b0 : w_hit[(g == 0) ? 0 : g - 1]),
                .o_data  (w_data[g]),
                .o_hit   (w_hit[g]),
                .o_tail  (w_tail[g])
            );
        end
    endgenerate

    always_comb begin
        tail_val = '0;
        for (int k = 0; k < DEPTH; k++) begin
            tail_val = tail_val | w_tail[k];
        end
    end

    assign accept = start && !r_listing;
    assign empty  = r_count == '0;
    assign full   = r_count == CW'(DEPTH);

    always_comb begin
        mode        = M_HOLD;
        n_count     = r_count;
        n_idx       = r_idx;
        n_listing   = r_listing;
        n_res_valid = 1'b0;
        n_res       = r_res;
        if (r_listing) begin
            mode             = M_ROTATE;
            n_res_valid      = 1'b1;
            n_res.status     = ST_OK;
            n_res.item_value = w_data[0];
            n_res.count      = CNT_W'(r_count);
            n_res.last       = CW'(r_idx + 1'b1) == r_count;
            n_idx            = CW'(r_idx + 1'b1);
            if (n_res.last) begin
                n_listing = 1'b0;
            end
        end else if (accept) begin
            n_res_valid      = 1'b1;
            n_res.status     = ST_OK;
            n_res.item_value = '0;
            n_res.last       = 1'b1;
            if ((i_req.func == F_INS_FRONT) || (i_req.func == F_INS_REAR)) begin
                if (full) begin
                    n_res.status = ST_FULL;
                end else begin
                    mode    = (i_req.func == F_INS_FRONT) ? M_INS_FRONT : M_INS_REAR;
                    n_count = CW'(r_count + 1'b1);
                end
            end else if ((i_req.func == F_DEL_FRONT) || (i_req.func == F_DEL_REAR)
                         || (i_req.func == F_DEL_VAL) || (i_req.func == F_LIST)) begin
                if (empty) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    unique case (i_req.func)
                        F_DEL_FRONT: begin
                            mode             = M_DEL_FRONT;
                            n_res.item_value = w_data[0];
                            n_count          = CW'(r_count - 1'b1);
                        end
                        F_DEL_REAR: begin
                            n_res.item_value = tail_val;
                            n_count          = CW'(r_count - 1'b1);
                        end
                        F_DEL_VAL: begin
                            if (w_hit[DEPTH-1]) begin
                                mode             = M_DEL_VAL;
                                n_res.item_value = i_req.value;
                                n_count          = CW'(r_count - 1'b1);
                            end else begin
                                n_res.status = ST_NOTFOUND;
                            end
                        end
                        default: begin
                            n_res_valid = 1'b0;
                            n_listing   = 1'b1;
                            n_idx       = '0;
                        end
                    endcase
                end
            end
            n_res.count = CNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_listing   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_listing   <= n_listing;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign busy        = r_listing;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// File: sv/dqdel_chk.sv
// ----------------------------------------------------------------------------
// dqdel_chk
// Port-level checks of the deque with delete-by-value, bound to the top.
// ----------------------------------------------------------------------------
module dqdel_chk #(
    parameter int DEPTH = dqdel_pkg::DQ_DEPTH
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input dqdel_pkg::t_dq_req  i_req,
    input logic                o_res_valid,
    input dqdel_pkg::t_dq_res  o_res
);
    import dqdel_pkg::*;

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.func != F_LIST) |=> o_res_valid && o_res.last)
        else $error("request without a single final result");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last |-> !busy)
        else $error("busy still high with final result");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status == ST_FULL) |-> o_res.count == CNT_W'(DEPTH))
        else $error("full status with wrong count");

    a_zero_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status != ST_OK) |-> o_res.item_value == '0)
        else $error("non-zero item on failed request");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_res_valid)
        else $error("not idle after reset");

endmodule

bind deque_with_delete_by_value dqdel_chk #(.DEPTH(DEPTH)) u_dqdel_chk (.*);

// File: tb/sv/deque_with_delete_by_value_tb.sv
// ----------------------------------------------------------------------------
// deque_with_delete_by_value_tb
// Self-checking bench for the deque with delete-by-value. A directed table
// covers the empty, full, not-found and unused-code cases and the tail and
// front edge cases; random phases follow (insert-heavy, delete-heavy, then
// balanced with no gaps). A predictor works out the results of each accepted
// request, and every strobed result is checked against the oldest one due.
// ----------------------------------------------------------------------------
module deque_with_delete_by_value_tb;

    import dqdel_pkg::*;

    localparam logic [2:0] F_SPARE_6   = 3'd6;
    localparam logic [2:0] F_SPARE_7   = 3'd7;
    localparam int         CYCLE_LIMIT = 200000;

    typedef struct {
        t_dq_req rq;
        int      reps;
        bit      typed;
        t_dq_res res;
    } t_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_dq_req i_req;
    logic    o_res_valid;
    t_dq_res o_res;

    // typed expectation travelling alongside the request
    bit      pin_typed;
    t_dq_res pin_res;

    logic signed [VAL_W-1:0] cells_q[$];
    t_dq_res                 res_due[$];
    t_dq_res                 chk_want;
    t_row                    plan[$];

    int errors  = 0;
    int n_req   = 0;
    int n_res   = 0;
    int n_full  = 0;
    int n_lists = 0;
    int cyc     = 0;

    deque_with_delete_by_value uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, res_due.size());
            $display("FAIL deque_with_delete_by_value");
            $finish;
        end
    end

    // predictor: applies one request to the local copy of the store
    task automatic deque_apply(input t_dq_req rq, input bit typed, input t_dq_res tres);
        t_dq_res r;
        int      idx;
        r        = '0;
        r.status = ST_OK;
        r.last   = 1'b1;
        idx      = -1;
        case (rq.func)
            F_INS_FRONT, F_INS_REAR: begin
                if (cells_q.size() >= DQ_DEPTH) begin
                    r.status = ST_FULL;
                end else if (rq.func == F_INS_FRONT) begin
                    cells_q.push_front(rq.value);
                end else begin
                    cells_q.push_back(rq.value);
                end
            end
            F_DEL_FRONT, F_DEL_REAR: begin
                if (cells_q.size() == 0) begin
                    r.status = ST_EMPTY;
                end else if (rq.func == F_DEL_FRONT) begin
                    r.item_value = cells_q.pop_front();
                end else begin
                    r.item_value = cells_q.pop_back();
                end
            end
            F_DEL_VAL: begin
                if (cells_q.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < cells_q.size() && idx < 0; i++)
                        if (cells_q[i] == rq.value) idx = i;
                    if (idx < 0) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        r.item_value = cells_q[idx];
                        cells_q.delete(idx);
                    end
                end
            end
            F_LIST: begin
                n_lists++;
                if (cells_q.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < cells_q.size() - 1; i++) begin
                        r.item_value = cells_q[i];
                        r.count      = CNT_W'(cells_q.size());
                        r.last       = 1'b0;
                        res_due.push_back(r);
                    end
                    r.item_value = cells_q[cells_q.size() - 1];
                    r.last       = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = CNT_W'(cells_q.size());
        res_due.push_back(typed ? tres : r);
    endtask

    task automatic field_cmp(input string fname, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h got %h", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_res_valid) begin
                if (res_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none got %p", $time, o_res);
                    errors++;
                end else begin
                    chk_want = res_due.pop_front();
                    field_cmp("status", 32'(chk_want.status), 32'(o_res.status));
                    field_cmp("item_value", chk_want.item_value, o_res.item_value);
                    field_cmp("count", 32'(chk_want.count), 32'(o_res.count));
                    field_cmp("last", 32'(chk_want.last), 32'(o_res.last));
                    n_res++;
                    if (o_res.status == ST_FULL) n_full++;
                end
            end
            if (start && !busy) begin
                deque_apply(i_req, pin_typed, pin_res);
                n_req++;
            end
        end
    end

    function automatic t_row mk_row(input logic [2:0] f, input logic [31:0] v, input int reps,
                                    input bit typed, input logic [1:0] st,
                                    input logic [31:0] iv, input int cnt);
        t_row r;
        r.rq.func        = f;
        r.rq.value       = v;
        r.reps           = reps;
        r.typed          = typed;
        r.res.status     = st;
        r.res.item_value = iv;
        r.res.count      = CNT_W'(cnt);
        r.res.last       = 1'b1;
        return r;
    endfunction

    // mode 0 insert-heavy, 1 delete-heavy, 2 balanced
    function automatic t_dq_req pick_req(input int mode);
        t_dq_req rq;
        int      w;
        int      vs;
        w  = $urandom_range(0, 99);
        vs = $urandom_range(0, 9);
        if (mode == 0) begin
            rq.func = w < 35 ? F_INS_FRONT : w < 65 ? F_INS_REAR : w < 72 ? F_DEL_FRONT :
                      w < 79 ? F_DEL_REAR : w < 90 ? F_DEL_VAL : w < 97 ? F_LIST : F_SPARE_6;
        end else if (mode == 1) begin
            rq.func = w < 15 ? F_INS_FRONT : w < 30 ? F_INS_REAR : w < 45 ? F_DEL_FRONT :
                      w < 60 ? F_DEL_REAR : w < 85 ? F_DEL_VAL : w < 96 ? F_LIST : F_SPARE_6;
        end else begin
            rq.func = w < 25 ? F_INS_FRONT : w < 50 ? F_INS_REAR : w < 60 ? F_DEL_FRONT :
                      w < 70 ? F_DEL_REAR : w < 85 ? F_DEL_VAL : w < 97 ? F_LIST : F_SPARE_6;
        end
        if (rq.func == F_SPARE_6 && $urandom_range(0, 1)) rq.func = F_SPARE_7;
        if (rq.func == F_DEL_VAL && vs < 5) vs = 8;
        if (vs < 5) begin
            rq.value = $urandom;
        end else if (vs < 7) begin
            rq.value = $urandom_range(0, 8) - 4;
        end else if (vs == 7) begin
            rq.value = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        end else if (cells_q.size() != 0) begin
            rq.value = cells_q[$urandom_range(0, cells_q.size() - 1)];
        end else begin
            rq.value = $urandom;
        end
        return rq;
    endfunction

    task automatic issue(input t_dq_req rq, input bit typed, input t_dq_res tres);
        start     <= 1'b1;
        i_req     <= rq;
        pin_typed <= typed;
        pin_res   <= tres;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic sender_gap(input int n);
        t_dq_req junk;
        junk.func  = 3'($urandom);
        junk.value = $urandom;
        start     <= 1'b0;
        i_req     <= junk;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (res_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    initial begin
        t_dq_req rq;
        int      n_items[3];
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_req     <= '0;
        pin_typed <= 1'b0;
        pin_res   <= '0;
        n_items   = '{100, 100, 50};

        plan.push_back(mk_row(F_LIST,      32'd0,         1,  1, ST_EMPTY,    32'd0, 0));
        plan.push_back(mk_row(F_DEL_FRONT, 32'd0,         1,  1, ST_EMPTY,    32'd0, 0));
        plan.push_back(mk_row(F_DEL_REAR,  32'd0,         1,  1, ST_EMPTY,    32'd0, 0));
        plan.push_back(mk_row(F_DEL_VAL,   32'd0,         1,  1, ST_EMPTY,    32'd0, 0));
        plan.push_back(mk_row(F_SPARE_6,   32'd5,         1,  1, ST_OK,       32'd0, 0));
        plan.push_back(mk_row(F_INS_FRONT, 32'h7fff_ffff, 1,  1, ST_OK,       32'd0, 1));
        plan.push_back(mk_row(F_INS_REAR,  32'h8000_0000, 1,  1, ST_OK,       32'd0, 2));
        plan.push_back(mk_row(F_INS_FRONT, 32'hffff_ffff, 1,  0, ST_OK,       32'd0, 0));
        plan.push_back(mk_row(F_LIST,      32'd0,         1,  0, ST_OK,       32'd0, 0));
        plan.push_back(mk_row(F_DEL_VAL,   32'h8000_0000, 1,  1, ST_OK, 32'h8000_0000, 2));
        plan.push_back(mk_row(F_DEL_VAL,   32'd12345,     1,  1, ST_NOTFOUND, 32'd0, 2));
        plan.push_back(mk_row(F_DEL_REAR,  32'd0,         1,  0, ST_OK,       32'd0, 0));
        plan.push_back(mk_row(F_DEL_FRONT, 32'd0,         1,  0, ST_OK,       32'd0, 0));
        plan.push_back(mk_row(F_INS_REAR,  32'd100,       16, 0, ST_OK,       32'd0, 0));
        plan.push_back(mk_row(F_INS_FRONT, 32'd0,         1,  1, ST_FULL,     32'd0, 16));
        plan.push_back(mk_row(F_INS_REAR,  32'd0,         1,  1, ST_FULL,     32'd0, 16));
        plan.push_back(mk_row(F_LIST,      32'd0,         1,  0, ST_OK,       32'd0, 0));
        plan.push_back(mk_row(F_DEL_VAL,   32'd115,       1,  1, ST_OK,       32'd115, 15));
        plan.push_back(mk_row(F_DEL_VAL,   32'd107,       1,  0, ST_OK,       32'd0, 0));
        plan.push_back(mk_row(F_SPARE_7,   32'hffff_ffff, 1,  0, ST_OK,       32'd0, 0));
        plan.push_back(mk_row(F_INS_FRONT, 32'd100,       1,  0, ST_OK,       32'd0, 0));
        plan.push_back(mk_row(F_DEL_VAL,   32'd100,       1,  0, ST_OK,       32'd0, 0));
        plan.push_back(mk_row(F_LIST,      32'd0,         1,  0, ST_OK,       32'd0, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            for (int k = 0; k < plan[r].reps; k++) begin
                rq       = plan[r].rq;
                rq.value = rq.value + k;
                issue(rq, plan[r].typed, plan[r].res);
            end
        end
        drain;

        for (int ph = 0; ph < 3; ph++) begin
            for (int n = 0; n < n_items[ph]; n++) begin
                issue(pick_req(ph), 1'b0, '0);
                if (ph < 2 && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 15));
            end
            drain;
        end

        $display("Ran %0d requests (%0d list requests), checked %0d results, %0d full rejects",
                 n_req, n_lists, n_res, n_full);
        $display("Directed edge cases, then insert-heavy, delete-heavy and gapless phases");
        if (errors == 0 && res_due.size() == 0) begin
            $display("PASS deque_with_delete_by_value");
        end else begin
            $display("%0t: %0d errors, %0d results never seen", $time, errors, res_due.size());
            $display("FAIL deque_with_delete_by_value");
        end
        $finish;
    end

endmodule
